// ===== design/bss_pkg.sv =====
// ----------------------------------------------------------------------------
// balance shunt scheduler package
// shared widths, function codes, register indexes and reset values
// ----------------------------------------------------------------------------
`default_nettype none

package bss_pkg;

    // sizing
    localparam int MODULES = 32;
    localparam int CELLS   = 12;
    localparam int MOD_AW  = (MODULES > 1) ? $clog2(MODULES) : 1;

    // fixed field widths
    localparam int MASK_W  = 16;
    localparam int MV_W    = 13;
    localparam int HYST_W  = 10;
    localparam int TEMP_W  = 9;
    localparam int MOD_W   = 5;
    localparam int CELL_W  = 4;
    localparam int FUNC_W  = 2;
    localparam int BIT_W   = $clog2(MASK_W);

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    // function codes
    localparam logic [FUNC_W-1:0] FUNC_CELL  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_PASS1 = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_PASS2 = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HYSTERESIS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_LIMIT = 2'd2;

    // register reset values
    localparam logic [MV_W-1:0]          THRESHOLD_RST  = 13'd3900;
    localparam logic [HYST_W-1:0]        HYSTERESIS_RST = 10'd10;
    localparam logic signed [TEMP_W-1:0] TEMP_LIMIT_RST = 9'sd100;

endpackage

`default_nettype wire

// ===== design/balance_shunt_scheduler.sv =====
// ----------------------------------------------------------------------------
// balance shunt scheduler
// per-module cell balancing request masks and nonoverlapping shunt patterns
// ----------------------------------------------------------------------------
//
// channel  | dir | handshake                  | fields
// ---------+-----+----------------------------+------------------------------
// command  | in  | start, busy                | func, module_req, cell_index,
//          |     |                            | cell_mv, pack_min_mv,
//          |     |                            | pack_max_mv, chip_temp
// result   | out | done (one cycle strobe)    | module_out, switch_mask,
//          |     |                            | cell_selected, forced_off
// config   | in  | cfg_valid, cfg_ready       | cfg_index, cfg_data
//
// a word is taken when start is high and busy is low; busy stays high until
// the result strobe cycle, one result word per command word
// cell sample: LOAD, WRITE, then the done register; shunt pass: LOAD, the
// pair scan (one bit position per cycle, 15 steps, skipped if forced), WRITE
// out of range module or unused function: done in the cycle after accept
// reset clears the per-module valid bits at once, no clearing pass
// the receiver cannot stall; cfg_ready is always high
//
`default_nettype none

module balance_shunt_scheduler (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    // command
    input  wire logic                                  start,
    output logic                                       busy,
    input  wire logic [bss_pkg::FUNC_W-1:0]            func,
    input  wire logic [bss_pkg::MOD_W-1:0]             module_req,
    input  wire logic [bss_pkg::CELL_W-1:0]            cell_index,
    input  wire logic [bss_pkg::MV_W-1:0]              cell_mv,
    input  wire logic [bss_pkg::MV_W-1:0]              pack_min_mv,
    input  wire logic [bss_pkg::MV_W-1:0]              pack_max_mv,
    input  wire logic signed [bss_pkg::TEMP_W-1:0]     chip_temp,
    // result
    output logic                                       done,
    output logic [bss_pkg::MOD_W-1:0]                  module_out,
    output logic [bss_pkg::MASK_W-1:0]                 switch_mask,
    output logic                                       cell_selected,
    output logic                                       forced_off,
    // config
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [bss_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [bss_pkg::CFG_DATA_W-1:0]        cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SCAN,
        ST_WRITE
    } state_t;

    // config registers
    logic [bss_pkg::MV_W-1:0]          thr_reg;
    logic [bss_pkg::HYST_W-1:0]        hyst_reg;
    logic signed [bss_pkg::TEMP_W-1:0] tlim_reg;

    // sequencer and command word
    state_t                            state_reg, state_next;
    logic [bss_pkg::FUNC_W-1:0]        func_reg, func_next;
    logic [bss_pkg::MOD_W-1:0]         mod_reg, mod_next;
    logic [bss_pkg::CELL_W-1:0]        cell_reg, cell_next;
    logic [bss_pkg::MV_W-1:0]          cmv_reg, cmv_next;
    logic [bss_pkg::MV_W-1:0]          pmin_reg, pmin_next;
    logic [bss_pkg::MV_W-1:0]          pmax_reg, pmax_next;
    logic signed [bss_pkg::TEMP_W-1:0] temp_reg, temp_next;

    // working masks
    logic [bss_pkg::MASK_W-1:0]        req_reg, req_next;
    logic [bss_pkg::MASK_W-1:0]        rem_reg, rem_next;
    logic [bss_pkg::MASK_W-1:0]        work_reg, work_next;
    logic [bss_pkg::BIT_W-1:0]         bit_reg, bit_next;
    logic                              sel_reg, sel_next;
    logic                              forced_reg, forced_next;

    // per-module valid bits
    logic [bss_pkg::MODULES-1:0]       valid_reg, valid_next;

    // result registers
    logic                              done_reg, done_next;
    logic [bss_pkg::MOD_W-1:0]         mout_reg, mout_next;
    logic [bss_pkg::MASK_W-1:0]        smask_reg, smask_next;
    logic                              osel_reg, osel_next;
    logic                              oforced_reg, oforced_next;

    // memory ports
    logic                              ram_we;
    logic                              ram_re;
    logic [bss_pkg::MOD_AW-1:0]        ram_raddr;
    logic [bss_pkg::MOD_AW-1:0]        idx;
    logic [bss_pkg::MASK_W-1:0]        req_rdata;
    logic [bss_pkg::MASK_W-1:0]        rem_rdata;

    // decode helpers
    logic                              accept;
    logic                              in_mod_ok;
    logic                              in_func_ok;
    logic                              cell_ok;
    logic                              sel_ok;
    logic                              force_cond;
    logic [bss_pkg::MV_W:0]            pmin_hyst;
    logic [bss_pkg::MASK_W-1:0]        cell_bit;
    logic [bss_pkg::MASK_W-1:0]        req_cur;
    logic [bss_pkg::MASK_W-1:0]        rem_cur;
    logic [bss_pkg::BIT_W-1:0]         bit_lo;

    assign accept     = start && (state_reg == ST_IDLE);
    assign busy       = (state_reg != ST_IDLE);
    assign cfg_ready  = 1'b1;
    assign in_mod_ok  = (32'(module_req) < bss_pkg::MODULES);
    assign in_func_ok = (func == bss_pkg::FUNC_CELL) || (func == bss_pkg::FUNC_PASS1)
                        || (func == bss_pkg::FUNC_PASS2);
    assign idx        = bss_pkg::MOD_AW'(mod_reg);
    assign ram_re     = accept;
    assign ram_raddr  = bss_pkg::MOD_AW'(module_req);
    assign ram_we     = (state_reg == ST_WRITE);

    // entry that was never written reads as zero
    assign req_cur = valid_reg[idx] ? req_rdata : '0;
    assign rem_cur = valid_reg[idx] ? rem_rdata : '0;

    // cell selection compare
    assign pmin_hyst = {1'b0, pmin_reg} + (bss_pkg::MV_W + 1)'(hyst_reg);
    assign sel_ok    = (cmv_reg >= thr_reg) && (pmin_hyst < {1'b0, cmv_reg});
    assign cell_ok   = (32'(cell_reg) < bss_pkg::CELLS);
    assign cell_bit  = bss_pkg::MASK_W'(1) << cell_reg;

    // force-off condition for shunt passes
    assign force_cond = (temp_reg > tlim_reg) || (pmax_reg < thr_reg);

    assign bit_lo = bit_reg - bss_pkg::BIT_W'(1);

    // request and remainder stores
    bss_ram #(
        .WIDTH (bss_pkg::MASK_W),
        .DEPTH (bss_pkg::MODULES)
    ) u_req_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx),
        .wdata (req_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (req_rdata)
    );

    bss_ram #(
        .WIDTH (bss_pkg::MASK_W),
        .DEPTH (bss_pkg::MODULES)
    ) u_rem_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx),
        .wdata (rem_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (rem_rdata)
    );

    // sequencer next state
    always_comb
    begin
        state_next   = state_reg;
        func_next    = func_reg;
        mod_next     = mod_reg;
        cell_next    = cell_reg;
        cmv_next     = cmv_reg;
        pmin_next    = pmin_reg;
        pmax_next    = pmax_reg;
        temp_next    = temp_reg;
        req_next     = req_reg;
        rem_next     = rem_reg;
        work_next    = work_reg;
        bit_next     = bit_reg;
        sel_next     = sel_reg;
        forced_next  = forced_reg;
        valid_next   = valid_reg;
        done_next    = 1'b0;
        mout_next    = mout_reg;
        smask_next   = smask_reg;
        osel_next    = osel_reg;
        oforced_next = oforced_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    func_next = func;
                    mod_next  = module_req;
                    cell_next = cell_index;
                    cmv_next  = cell_mv;
                    pmin_next = pack_min_mv;
                    pmax_next = pack_max_mv;
                    temp_next = chip_temp;
                    if (in_mod_ok && in_func_ok)
                    begin
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        // nothing to do: echo the module, all else zero
                        done_next    = 1'b1;
                        mout_next    = module_req;
                        smask_next   = '0;
                        osel_next    = 1'b0;
                        oforced_next = 1'b0;
                    end
                end
            end

            ST_LOAD:
            begin
                req_next    = req_cur;
                rem_next    = rem_cur;
                sel_next    = 1'b0;
                forced_next = 1'b0;
                work_next   = '0;
                if (func_reg == bss_pkg::FUNC_CELL)
                begin
                    // set or clear one request bit
                    if (cell_ok)
                    begin
                        if (sel_ok)
                        begin
                            req_next = req_cur | cell_bit;
                            sel_next = 1'b1;
                        end
                        else
                        begin
                            req_next = req_cur & ~cell_bit;
                        end
                    end
                    state_next = ST_WRITE;
                end
                else if (force_cond)
                begin
                    // overtemperature or low pack clears the module
                    req_next    = '0;
                    rem_next    = '0;
                    forced_next = 1'b1;
                    state_next  = ST_WRITE;
                end
                else
                begin
                    // first pass starts from an empty remainder
                    if (func_reg == bss_pkg::FUNC_PASS1)
                    begin
                        work_next = req_cur;
                    end
                    else
                    begin
                        work_next = req_cur ^ rem_cur;
                    end
                    rem_next   = '0;
                    bit_next   = bss_pkg::BIT_W'(1);
                    state_next = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                // one adjacent pair per cycle: keep lower, drop upper
                if (work_reg[bit_lo] && work_reg[bit_reg])
                begin
                    work_next          = work_reg;
                    work_next[bit_reg] = 1'b0;
                    rem_next           = rem_reg;
                    rem_next[bit_lo]   = 1'b1;
                end
                if (bit_reg == bss_pkg::BIT_W'(bss_pkg::MASK_W - 1))
                begin
                    state_next = ST_WRITE;
                end
                else
                begin
                    bit_next = bit_reg + bss_pkg::BIT_W'(1);
                end
            end

            ST_WRITE:
            begin
                // masks go back to the stores, result word goes out
                valid_next[idx] = 1'b1;
                done_next       = 1'b1;
                mout_next       = mod_reg;
                osel_next       = sel_reg;
                oforced_next    = forced_reg;
                if ((func_reg == bss_pkg::FUNC_CELL) || forced_reg)
                begin
                    smask_next = '0;
                end
                else
                begin
                    smask_next = work_reg;
                end
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            func_reg    <= '0;
            mod_reg     <= '0;
            cell_reg    <= '0;
            cmv_reg     <= '0;
            pmin_reg    <= '0;
            pmax_reg    <= '0;
            temp_reg    <= '0;
            req_reg     <= '0;
            rem_reg     <= '0;
            work_reg    <= '0;
            bit_reg     <= '0;
            sel_reg     <= 1'b0;
            forced_reg  <= 1'b0;
            valid_reg   <= '0;
            done_reg    <= 1'b0;
            mout_reg    <= '0;
            smask_reg   <= '0;
            osel_reg    <= 1'b0;
            oforced_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            func_reg    <= func_next;
            mod_reg     <= mod_next;
            cell_reg    <= cell_next;
            cmv_reg     <= cmv_next;
            pmin_reg    <= pmin_next;
            pmax_reg    <= pmax_next;
            temp_reg    <= temp_next;
            req_reg     <= req_next;
            rem_reg     <= rem_next;
            work_reg    <= work_next;
            bit_reg     <= bit_next;
            sel_reg     <= sel_next;
            forced_reg  <= forced_next;
            valid_reg   <= valid_next;
            done_reg    <= done_next;
            mout_reg    <= mout_next;
            smask_reg   <= smask_next;
            osel_reg    <= osel_next;
            oforced_reg <= oforced_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg  <= bss_pkg::THRESHOLD_RST;
            hyst_reg <= bss_pkg::HYSTERESIS_RST;
            tlim_reg <= bss_pkg::TEMP_LIMIT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                bss_pkg::REG_THRESHOLD:
                begin
                    thr_reg <= cfg_data[bss_pkg::MV_W-1:0];
                end
                bss_pkg::REG_HYSTERESIS:
                begin
                    hyst_reg <= cfg_data[bss_pkg::HYST_W-1:0];
                end
                bss_pkg::REG_TEMP_LIMIT:
                begin
                    tlim_reg <= $signed(cfg_data[bss_pkg::TEMP_W-1:0]);
                end
                default:
                begin
                    thr_reg <= thr_reg;
                end
            endcase
        end
    end

    assign done          = done_reg;
    assign module_out    = mout_reg;
    assign switch_mask   = smask_reg;
    assign cell_selected = osel_reg;
    assign forced_off    = oforced_reg;

endmodule

`default_nettype wire

// ===== design/bss_ram.sv =====
// ----------------------------------------------------------------------------
// bss_ram
// generic single write, single read memory with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module bss_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== dv/bss_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// balance shunt scheduler checker
// watches the command, result and config channels, keeps its own per-module
// request and remainder masks, predicts one result word per command word and
// compares every result word field by field against the oldest prediction
// ----------------------------------------------------------------------------

module bss_checker
    import bss_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    // command channel
    input  wire logic                      start,
    input  wire logic                      busy,
    input  wire logic [FUNC_W-1:0]         func,
    input  wire logic [MOD_W-1:0]          module_req,
    input  wire logic [CELL_W-1:0]         cell_index,
    input  wire logic [MV_W-1:0]           cell_mv,
    input  wire logic [MV_W-1:0]           pack_min_mv,
    input  wire logic [MV_W-1:0]           pack_max_mv,
    input  wire logic signed [TEMP_W-1:0]  chip_temp,
    // result channel
    input  wire logic                      done,
    input  wire logic [MOD_W-1:0]          module_out,
    input  wire logic [MASK_W-1:0]         switch_mask,
    input  wire logic                      cell_selected,
    input  wire logic                      forced_off,
    // config channel
    input  wire logic                      cfg_valid,
    input  wire logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [CFG_DATA_W-1:0]     cfg_data,
    // status to the top
    output int                             errors,
    output int                             outstanding
);

    typedef struct packed {
        logic [MOD_W-1:0]  module_id;
        logic [MASK_W-1:0] shunts;
        logic              selected;
        logic              forced;
    } shunt_word_t;

    shunt_word_t       shunt_words_q[$];
    logic [MASK_W-1:0] request_bits [MODULES];
    logic [MASK_W-1:0] carry_bits   [MODULES];

    logic [MV_W-1:0]          threshold;
    logic [HYST_W-1:0]        hysteresis;
    logic signed [TEMP_W-1:0] temp_limit;

    initial errors = 0;

    // low to high pair scan: keep the lower bit of each adjacent pair
    function automatic logic [MASK_W-1:0] split_pairs(input logic [MASK_W-1:0] pattern,
                                                      output logic [MASK_W-1:0] kept);
        logic [MASK_W-1:0] work;
        work = pattern;
        kept = '0;
        for (int i = 1; i < MASK_W; i++) begin
            if (work[i-1] && work[i]) begin
                work[i]   = 1'b0;
                kept[i-1] = 1'b1;
            end
        end
        return work;
    endfunction

    // expected result word for one command word, updates the module masks
    function automatic shunt_word_t schedule_word(input logic [FUNC_W-1:0] f,
                                                  input logic [MOD_W-1:0] m,
                                                  input logic [CELL_W-1:0] c,
                                                  input logic [MV_W-1:0] cmv,
                                                  input logic [MV_W-1:0] pmin,
                                                  input logic [MV_W-1:0] pmax,
                                                  input logic signed [TEMP_W-1:0] t);
        shunt_word_t       res;
        logic [MASK_W-1:0] kept;
        res           = '0;
        res.module_id = m;
        if (int'(m) < MODULES) begin
            case (f)
                FUNC_CELL:
                begin
                    // cells past the module size are ignored
                    if (int'(c) < CELLS) begin
                        if (cmv >= threshold &&
                            int'(pmin) + int'(hysteresis) < int'(cmv)) begin
                            request_bits[m][c] = 1'b1;
                            res.selected       = 1'b1;
                        end else begin
                            request_bits[m][c] = 1'b0;
                        end
                    end
                end
                FUNC_PASS1, FUNC_PASS2:
                begin
                    if (f == FUNC_PASS1)
                        carry_bits[m] = '0;
                    // overtemperature or low pack clears the module
                    if (t > temp_limit || pmax < threshold) begin
                        request_bits[m] = '0;
                        carry_bits[m]   = '0;
                        res.forced      = 1'b1;
                    end else begin
                        res.shunts    = split_pairs(request_bits[m] ^ carry_bits[m], kept);
                        carry_bits[m] = kept;
                    end
                end
                default:
                begin
                end
            endcase
        end
        return res;
    endfunction

    function automatic void check_field(input string field, input int want, input int got);
        if (want != got) begin
            errors++;
            $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        shunt_word_t want_w;
        if (!rst_n) begin
            for (int m = 0; m < MODULES; m++) begin
                request_bits[m] = '0;
                carry_bits[m]   = '0;
            end
            threshold  = THRESHOLD_RST;
            hysteresis = HYSTERESIS_RST;
            temp_limit = TEMP_LIMIT_RST;
            shunt_words_q.delete();
            outstanding = 0;
        end else begin
            // result word against the oldest prediction
            if (done) begin
                if (shunt_words_q.size() == 0) begin
                    errors++;
                    $display("%0t: result word for module %0d with none outstanding",
                             $time, module_out);
                end else begin
                    want_w = shunt_words_q.pop_front();
                    check_field("module_out", want_w.module_id, module_out);
                    check_field("switch_mask", want_w.shunts, switch_mask);
                    check_field("cell_selected", want_w.selected, cell_selected);
                    check_field("forced_off", want_w.forced, forced_off);
                end
            end

            // register writes
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_THRESHOLD:  threshold  = cfg_data[MV_W-1:0];
                    REG_HYSTERESIS: hysteresis = cfg_data[HYST_W-1:0];
                    REG_TEMP_LIMIT: temp_limit = cfg_data[TEMP_W-1:0];
                    default:        ;
                endcase
            end

            // accepted command word
            if (start && !busy)
                shunt_words_q.push_back(schedule_word(func, module_req, cell_index, cell_mv,
                                                      pack_min_mv, pack_max_mv, chip_temp));
            outstanding = shunt_words_q.size();
        end
    end

endmodule

// ===== dv/balance_shunt_scheduler_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// balance shunt scheduler testbench
// drives directed and random command words through several register settings
// with random sender pacing in most phases; the checker beside the block predicts and
// compares each result word, and this top gives the verdict
// ----------------------------------------------------------------------------

module balance_shunt_scheduler_tb;
    import bss_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam int STALL_LIMIT   = 2000;
    localparam int PHASE_WORDS   = 100;
    localparam int SETTLE_CYCLES = 24;

    logic                     clk;
    logic                     rst_n       = 1'b0;
    logic                     start       = 1'b0;
    logic                     busy;
    logic [FUNC_W-1:0]        func        = '0;
    logic [MOD_W-1:0]         module_req  = '0;
    logic [CELL_W-1:0]        cell_index  = '0;
    logic [MV_W-1:0]          cell_mv     = '0;
    logic [MV_W-1:0]          pack_min_mv = '0;
    logic [MV_W-1:0]          pack_max_mv = '0;
    logic signed [TEMP_W-1:0] chip_temp   = '0;
    logic                     done;
    logic [MOD_W-1:0]         module_out;
    logic [MASK_W-1:0]        switch_mask;
    logic                     cell_selected;
    logic                     forced_off;
    logic                     cfg_valid   = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index   = '0;
    logic [CFG_DATA_W-1:0]    cfg_data    = '0;

    int mismatches;
    int outstanding;

    // current register values, used to shape well-formed words
    int thr_mv   = THRESHOLD_RST;
    int hyst_mv  = HYSTERESIS_RST;
    int temp_lim = TEMP_LIMIT_RST;
    bit pace_on  = 1'b1;

    int n_cell;
    int n_pass;
    int n_other;
    int n_settings;
    int stall_cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    balance_shunt_scheduler dut (
        .clk(clk), .rst_n(rst_n),
        .start(start), .busy(busy), .func(func), .module_req(module_req),
        .cell_index(cell_index), .cell_mv(cell_mv), .pack_min_mv(pack_min_mv),
        .pack_max_mv(pack_max_mv), .chip_temp(chip_temp),
        .done(done), .module_out(module_out), .switch_mask(switch_mask),
        .cell_selected(cell_selected), .forced_off(forced_off),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    bss_checker shunt_check (
        .clk(clk), .rst_n(rst_n),
        .start(start), .busy(busy), .func(func), .module_req(module_req),
        .cell_index(cell_index), .cell_mv(cell_mv), .pack_min_mv(pack_min_mv),
        .pack_max_mv(pack_max_mv), .chip_temp(chip_temp),
        .done(done), .module_out(module_out), .switch_mask(switch_mask),
        .cell_selected(cell_selected), .forced_off(forced_off),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .errors(mismatches), .outstanding(outstanding)
    );

    // watchdog on cycles with no handshake on any channel
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("balance_shunt_scheduler: mismatch");
            $finish;
        end
    end

    // one command word, with random pacing ahead of it
    task automatic send_word(input logic [FUNC_W-1:0] f, input logic [MOD_W-1:0] m,
                             input logic [CELL_W-1:0] c, input logic [MV_W-1:0] cmv,
                             input logic [MV_W-1:0] pmin, input logic [MV_W-1:0] pmax,
                             input logic signed [TEMP_W-1:0] t);
        while (pace_on && $urandom_range(99) < 36) begin
            start <= 1'b0;
            @(posedge clk);
        end
        start       <= 1'b1;
        func        <= f;
        module_req  <= m;
        cell_index  <= c;
        cell_mv     <= cmv;
        pack_min_mv <= pmin;
        pack_max_mv <= pmax;
        chip_temp   <= t;
        do @(posedge clk); while (busy);
        case (f)
            FUNC_CELL:              n_cell++;
            FUNC_PASS1, FUNC_PASS2: n_pass++;
            default:                n_other++;
        endcase
    endtask

    // random word: mostly well-formed traffic on a few modules, the rest noise
    task automatic random_word();
        logic [FUNC_W-1:0]        f;
        logic [MOD_W-1:0]         m;
        logic [CELL_W-1:0]        c;
        logic [MV_W-1:0]          cmv;
        logic [MV_W-1:0]          pmin;
        logic [MV_W-1:0]          pmax;
        logic signed [TEMP_W-1:0] t;
        int                       pick;
        f    = 2'($urandom_range(3));
        m    = 5'($urandom);
        c    = 4'($urandom);
        cmv  = 13'($urandom);
        pmin = 13'($urandom);
        pmax = 13'($urandom);
        t    = 9'($urandom);
        if ($urandom_range(99) < 80) begin
            // few modules so the masks fill up and pairs form
            m    = 5'($urandom_range(3));
            pick = $urandom_range(9);
            if (pick < 6) begin
                f = FUNC_CELL;
                c = 4'($urandom_range(CELLS - 1));
                if ($urandom_range(3) != 0) begin
                    cmv = 13'($urandom_range(8191, thr_mv));
                    if (int'(cmv) > hyst_mv)
                        pmin = 13'($urandom_range(int'(cmv) - hyst_mv - 1, 0));
                end
            end else begin
                f = (pick < 8) ? FUNC_PASS1 : FUNC_PASS2;
                if ($urandom_range(9) != 0) begin
                    pmax = 13'($urandom_range(8191, thr_mv));
                    t    = 9'($urandom_range(temp_lim + 256, 0) - 256);
                end
            end
        end
        send_word(f, m, c, cmv, pmin, pmax, t);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // returns at a rising edge once every result word has come back
    task automatic wait_drained();
        do @(negedge clk); while (outstanding != 0);
        @(posedge clk);
    endtask

    // new register setting, only with the block idle
    task automatic apply_settings(input int thr, input int hyst, input int tlim);
        start <= 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_write(REG_THRESHOLD, 13'(thr));
        cfg_write(REG_HYSTERESIS, {3'($urandom_range(7)), 10'(hyst)});
        cfg_write(REG_TEMP_LIMIT, {4'($urandom_range(15)), 9'(tlim)});
        cfg_valid <= 1'b0;
        thr_mv   = thr;
        hyst_mv  = hyst;
        temp_lim = tlim;
        n_settings++;
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed words with reset register values, module 0 mostly
        send_word(FUNC_CELL, 5'd0, 4'd0, 13'd4000, 13'd3000, 13'd0, 9'sd0);
        send_word(FUNC_CELL, 5'd0, 4'd1, 13'd4000, 13'd3000, 13'd0, 9'sd0);
        send_word(FUNC_CELL, 5'd0, 4'd2, 13'd4000, 13'd3000, 13'd0, 9'sd0);
        // hysteresis edge, not selected
        send_word(FUNC_CELL, 5'd0, 4'd3, 13'd3900, 13'd3890, 13'd0, 9'sd0);
        // threshold edge, selected
        send_word(FUNC_CELL, 5'd0, 4'd4, 13'd3900, 13'd3889, 13'd0, 9'sd0);
        // just below threshold
        send_word(FUNC_CELL, 5'd0, 4'd5, 13'd3899, 13'd0, 13'd0, 9'sd0);
        send_word(FUNC_CELL, 5'd0, 4'd11, 13'd8191, 13'd0, 13'd8191, 9'sd0);
        // cells past the module size
        send_word(FUNC_CELL, 5'd0, 4'd12, 13'd5000, 13'd0, 13'd0, 9'sd0);
        send_word(FUNC_CELL, 5'd0, 4'd15, 13'd8191, 13'd0, 13'd8191, 9'sh100);
        send_word(FUNC_CELL, 5'd0, 4'd10, 13'd8191, 13'd8191, 13'd0, 9'sd0);
        send_word(FUNC_CELL, 5'd0, 4'd9, 13'd0, 13'd0, 13'd0, 9'sd0);
        // passes at the temperature and pack edges, not forced
        send_word(FUNC_PASS1, 5'd0, 4'd0, 13'd0, 13'd0, 13'd3900, 9'sd100);
        send_word(FUNC_PASS2, 5'd0, 4'd0, 13'd0, 13'd0, 13'd3900, 9'sd100);
        send_word(FUNC_PASS2, 5'd0, 4'd0, 13'd0, 13'd0, 13'd8191, 9'sh100);
        send_word(FUNC_PASS1, 5'd5, 4'd0, 13'd0, 13'd0, 13'd4000, 9'sd0);
        // unused function code with every field at all ones
        send_word(FUNC_UNUSED, 5'd31, 4'd15, 13'd8191, 13'd8191, 13'd8191, -9'sd1);
        // overtemperature, then a pass that is not forced, then low pack on module 1
        send_word(FUNC_PASS1, 5'd0, 4'd0, 13'd0, 13'd0, 13'd8191, 9'sd101);
        send_word(FUNC_PASS2, 5'd0, 4'd0, 13'd0, 13'd0, 13'd8191, 9'sd0);
        send_word(FUNC_CELL, 5'd1, 4'd0, 13'd4000, 13'd0, 13'd0, 9'sd0);
        send_word(FUNC_PASS2, 5'd1, 4'd0, 13'd0, 13'd0, 13'd3899, 9'sd0);
        send_word(FUNC_CELL, 5'd31, 4'd0, 13'd8191, 13'd0, 13'd0, 9'sd0);
        send_word(FUNC_PASS1, 5'd31, 4'd0, 13'd0, 13'd0, 13'd8191, 9'sh100);

        // random phases over register settings, lowest and highest included
        apply_settings(0, 0, -256);
        repeat (PHASE_WORDS) random_word();
        apply_settings(8191, 1023, 255);
        repeat (PHASE_WORDS) random_word();
        apply_settings($urandom_range(4200, 3000), $urandom_range(200), $urandom_range(120));
        repeat (PHASE_WORDS) random_word();
        // back-to-back stretch with no sender pacing
        pace_on = 1'b0;
        apply_settings(THRESHOLD_RST, HYSTERESIS_RST, TEMP_LIMIT_RST);
        repeat (PHASE_WORDS) random_word();
        pace_on = 1'b1;
        apply_settings(3600, 40, -20);
        repeat (PHASE_WORDS) random_word();
        start <= 1'b0;

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("covered %0d cell samples, %0d shunt passes, %0d unused-code words",
                 n_cell, n_pass, n_other);
        $display("over reset values and %0d register settings, paced and back to back",
                 n_settings);
        if (mismatches == 0 && outstanding == 0)
            $display("balance_shunt_scheduler: match");
        else
            $display("balance_shunt_scheduler: mismatch");
        $finish;
    end

endmodule
